// File: rtl/obb_pkg.sv
// obb_pkg: shared widths and a packed box type for the box overlap test core
// no dependencies

package obb_pkg;

    localparam int COORD_BITS = 24;
    localparam int DIR_FRAC_BITS = 14;
    localparam int DIR_BITS = DIR_FRAC_BITS + 2;
    localparam int SIZE_BITS = 16;
    localparam int IN_BITS = 4 * COORD_BITS + 4 * DIR_BITS + 4 * SIZE_BITS;
    localparam int IN_BYTES_BITS = ((IN_BITS + 7) / 8) * 8;
    localparam int DIFF_BITS = COORD_BITS + 1;
    localparam int DOT_BITS = 2 * DIR_BITS + 1;

    typedef struct packed {
        logic signed [SIZE_BITS:0]     length;
        logic signed [SIZE_BITS:0]     width;
        logic signed [DIR_BITS-1:0]    dir_y;
        logic signed [DIR_BITS-1:0]    dir_x;
        logic signed [COORD_BITS-1:0]  center_y;
        logic signed [COORD_BITS-1:0]  center_x;
    } box_t;

endpackage

// File: rtl/obb_overlap_test_core.sv
// obb_overlap_test_core: separating-axis overlap test of two oriented rectangles
// depends on obb_pkg
//
// result word is registered at the last of the stages listed below
// throughput: one box pair per cycle, stalls freeze the whole pipeline
// reset: rst_n asynchronous active low clears all stage valid bits
// stages: unpack/diff, dot products, magnitudes times sizes, sums, compares

module obb_overlap_test_core
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // a_center_x, a_center_y, a_dir_x, a_dir_y, a_width, a_length, then b same
    input  logic [obb_pkg::IN_BYTES_BITS-1:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // collide, degenerate
    output logic [7:0]   m_axis_tdata
);

    localparam int CB = obb_pkg::COORD_BITS;
    localparam int DB = obb_pkg::DIR_BITS;
    localparam int SB = obb_pkg::SIZE_BITS;
    localparam int FB = obb_pkg::DIR_FRAC_BITS;
    localparam int DF = obb_pkg::DIFF_BITS;
    localparam int DT = obb_pkg::DOT_BITS;
    localparam int PB = DF + DB + 1;       // d.u
    localparam int EB = DT + SB;           // size * |dot|
    localparam int XB = EB + 2;            // sum of four extents
    localparam int BOX_BITS = 2 * CB + 2 * DB + 2 * SB;
    localparam int SQ = 2 * DF + 2;        // squared distance and bound

    // whole pipeline advances together
    logic adv;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    assign adv = !v5_reg || m_axis_tready;
    assign s_axis_tready = adv;

    function automatic obb_pkg::box_t unpack_box(input logic [BOX_BITS-1:0] r);
        obb_pkg::box_t b;
        b.center_x = r[CB-1:0];
        b.center_y = r[2*CB-1:CB];
        b.dir_x    = r[2*CB+DB-1:2*CB];
        b.dir_y    = r[2*CB+2*DB-1:2*CB+DB];
        b.width    = {1'b0, r[2*CB+2*DB+SB-1:2*CB+2*DB]};
        b.length   = {1'b0, r[BOX_BITS-1:2*CB+2*DB+SB]};
        return b;
    endfunction

    // ---------------- stage 1: unpack, center difference, flags
    obb_pkg::box_t a_in, b_in;
    assign a_in = unpack_box(s_axis_tdata[BOX_BITS-1:0]);
    assign b_in = unpack_box(s_axis_tdata[2*BOX_BITS-1:BOX_BITS]);

    obb_pkg::box_t a1_reg, b1_reg;
    logic signed [DF-1:0] dx1_reg, dy1_reg;
    logic degen1_reg, zdir1_reg;
    logic [SB:0] s1_reg;   // max dim A + max dim B

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a1_reg <= a_in;
            b1_reg <= b_in;
            dx1_reg <= DF'(b_in.center_x) - DF'(a_in.center_x);
            dy1_reg <= DF'(b_in.center_y) - DF'(a_in.center_y);
            degen1_reg <= (a_in.width == '0) || (a_in.length == '0)
                       || (b_in.width == '0) || (b_in.length == '0);
            zdir1_reg <= (a_in.dir_x == '0 && a_in.dir_y == '0)
                      || (b_in.dir_x == '0 && b_in.dir_y == '0);
            s1_reg <= (SB+1)'(a_in.width > a_in.length ? a_in.width[SB-1:0]
                                                       : a_in.length[SB-1:0])
                    + (SB+1)'(b_in.width > b_in.length ? b_in.width[SB-1:0]
                                                       : b_in.length[SB-1:0]);
        end
    end

    // ---------------- stage 2: dot products for four axes
    // axes: fA, rA=(fAy,-fAx), fB, rB; for each axis u the dots
    // fA.u, rA.u, fB.u, rB.u and d.u

    // components are sign-extended by one bit so a negated -2^15 stays exact
    function automatic logic signed [DT-1:0] dot(input logic signed [DB:0] px,
        input logic signed [DB:0] py, input logic signed [DB:0] qx,
        input logic signed [DB:0] qy);
        return DT'(px * qx) + DT'(py * qy);
    endfunction

    logic signed [DT-1:0] fa2_reg [4], ra2_reg [4], fb2_reg [4], rb2_reg [4];
    logic signed [PB-1:0] du2_reg [4];
    logic [SB-1:0] aw2_reg, al2_reg, bw2_reg, bl2_reg;
    logic [DF-1:0] adx2_reg, ady2_reg;
    logic [SB:0] s2_reg;
    logic pre2_reg, degen2_reg;

    logic signed [DB:0] axe [4];
    logic signed [DB:0] aye [4];
    always_comb
    begin
        axe[0] = {a1_reg.dir_x[DB-1], a1_reg.dir_x};
        aye[0] = {a1_reg.dir_y[DB-1], a1_reg.dir_y};
        axe[1] = {a1_reg.dir_y[DB-1], a1_reg.dir_y};
        aye[1] = -{a1_reg.dir_x[DB-1], a1_reg.dir_x};
        axe[2] = {b1_reg.dir_x[DB-1], b1_reg.dir_x};
        aye[2] = {b1_reg.dir_y[DB-1], b1_reg.dir_y};
        axe[3] = {b1_reg.dir_y[DB-1], b1_reg.dir_y};
        aye[3] = -{b1_reg.dir_x[DB-1], b1_reg.dir_x};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 4; i++)
            begin
                fa2_reg[i] <= dot(axe[0], aye[0], axe[i], aye[i]);
                ra2_reg[i] <= dot(axe[1], aye[1], axe[i], aye[i]);
                fb2_reg[i] <= dot(axe[2], aye[2], axe[i], aye[i]);
                rb2_reg[i] <= dot(axe[3], aye[3], axe[i], aye[i]);
                du2_reg[i] <= PB'(dx1_reg * axe[i]) + PB'(dy1_reg * aye[i]);
            end
            aw2_reg <= a1_reg.width[SB-1:0];
            al2_reg <= a1_reg.length[SB-1:0];
            bw2_reg <= b1_reg.width[SB-1:0];
            bl2_reg <= b1_reg.length[SB-1:0];
            adx2_reg <= dx1_reg[DF-1] ? DF'(-dx1_reg) : DF'(dx1_reg);
            ady2_reg <= dy1_reg[DF-1] ? DF'(-dy1_reg) : DF'(dy1_reg);
            s2_reg <= s1_reg;
            pre2_reg <= !degen1_reg && !zdir1_reg;
            degen2_reg <= degen1_reg;
        end
    end

    // ---------------- stage 3: size times |dot|, circle squares
    function automatic logic [DT-1:0] absd(input logic signed [DT-1:0] v);
        return v[DT-1] ? DT'(-v) : DT'(v);
    endfunction

    logic [EB-1:0] e3_reg [4][4];   // [axis][la, wa, lb, wb]
    logic [PB-1:0] ad3_reg [4];
    logic [SQ-1:0] dsq3_reg, ssq3_reg;
    logic rj3_reg, pre3_reg, degen3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 4; i++)
            begin
                e3_reg[i][0] <= EB'(al2_reg * absd(fa2_reg[i]));
                e3_reg[i][1] <= EB'(aw2_reg * absd(ra2_reg[i]));
                e3_reg[i][2] <= EB'(bl2_reg * absd(fb2_reg[i]));
                e3_reg[i][3] <= EB'(bw2_reg * absd(rb2_reg[i]));
                ad3_reg[i] <= du2_reg[i][PB-1] ? PB'(-du2_reg[i]) : PB'(du2_reg[i]);
            end
            dsq3_reg <= SQ'(adx2_reg * adx2_reg) + SQ'(ady2_reg * ady2_reg);
            ssq3_reg <= SQ'(s2_reg * s2_reg);
            rj3_reg <= ({adx2_reg, 1'b0} > (DF+1)'(s2_reg))
                    || ({ady2_reg, 1'b0} > (DF+1)'(s2_reg));
            pre3_reg <= pre2_reg;
            degen3_reg <= degen2_reg;
        end
    end

    // ---------------- stage 4: extent sums, circle compare
    logic [XB-FB-1:0] rhs4_reg [4];
    logic [PB:0] lhs4_reg [4];
    logic ok4_reg, degen4_reg;
    logic [XB-1:0] xsum [4];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            xsum[i] = XB'(e3_reg[i][0]) + XB'(e3_reg[i][1])
                    + XB'(e3_reg[i][2]) + XB'(e3_reg[i][3]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 4; i++)
            begin
                rhs4_reg[i] <= xsum[i][XB-1:FB];
                lhs4_reg[i] <= {ad3_reg[i], 1'b0};
            end
            ok4_reg <= pre3_reg && !rj3_reg
                    && !({dsq3_reg[SQ-3:0], 2'b00} > ssq3_reg)
                    && (dsq3_reg[SQ-1:SQ-2] == 2'b00);
            degen4_reg <= degen3_reg;
        end
    end

    // ---------------- stage 5: axis compares, output register
    logic collide5_reg, degen5_reg;
    logic all_ok;
    always_comb
    begin
        all_ok = ok4_reg;
        for (int i = 0; i < 4; i++)
        begin
            if ((PB+1 > XB-FB ? lhs4_reg[i] > (PB+1)'(rhs4_reg[i])
                              : (XB-FB)'(lhs4_reg[i]) > rhs4_reg[i]))
            begin
                all_ok = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
        end
        else if (adv)
        begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            collide5_reg <= all_ok;
            degen5_reg <= degen4_reg;
        end
    end

    assign m_axis_tvalid = v5_reg;
    assign m_axis_tdata = {6'b0, degen5_reg, collide5_reg};

    // ---------------- checks
    a_degen_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
        else $error("collide set on degenerate pair");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

endmodule
